[src/bpnge_pkg.sv]
// Shared types and codes for the bit-parallel netlist gate evaluator.
`default_nettype none

package bpnge_pkg;

    localparam int NODE_W     = 10;
    localparam int WORD_IDX_W = 4;
    localparam int GATE_W     = 5;
    localparam int PAT_W      = 64;
    localparam int FANINS     = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [GATE_W-1:0] {
        GATE_BUF    = 5'd0,
        GATE_INV    = 5'd1,
        GATE_XOR    = 5'd2,
        GATE_XNOR   = 5'd3,
        GATE_AND2   = 5'd4,
        GATE_OR2    = 5'd5,
        GATE_NAND2  = 5'd6,
        GATE_NAND3  = 5'd7,
        GATE_NAND4  = 5'd8,
        GATE_NOR2   = 5'd9,
        GATE_NOR3   = 5'd10,
        GATE_NOR4   = 5'd11,
        GATE_AOI21  = 5'd12,
        GATE_AOI22  = 5'd13,
        GATE_OAI21  = 5'd14,
        GATE_OAI22  = 5'd15,
        GATE_CONST0 = 5'd16,
        GATE_CONST1 = 5'd17
    } gate_type_t;

    typedef struct packed {
        logic                  op;
        logic [GATE_W-1:0]     gate_type;
        logic [NODE_W-1:0]     dest_node;
        logic [WORD_IDX_W-1:0] word_index;
        logic [NODE_W-1:0]     fanin_a;
        logic [NODE_W-1:0]     fanin_b;
        logic [NODE_W-1:0]     fanin_c;
        logic [NODE_W-1:0]     fanin_d;
        logic [PAT_W-1:0]      load_word;
    } bpnge_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic [PAT_W-1:0]  result_word;
    } bpnge_out_t;

endpackage

`default_nettype wire

[src/bit_parallel_netlist_gate_evaluator_unit.sv]
// Top level of the bit-parallel netlist gate evaluator.
//
// Input channel s_valid/s_ready/s_data carries one item per transfer: either a
// load of a 64-pattern word into (dest_node, word_index), or a gate evaluation
// that reads fanins a..d at the same word index and stores the gate output.
// Each item produces exactly one transfer on m_valid/m_ready/m_data holding the
// node written and the 64-bit word now stored for it.
// The transfer edge does the store read and loads the evaluate stage; when
// that stage advances, it evaluates, writes back and loads the output
// register, which presents the result on m_valid/m_data.
// Throughput: one item per cycle while m_ready stays high. Each of the four fanin ports has
// its own memory copy with one read port; all copies share the write port, and
// the word written on the edge of a read is forwarded into that read.
// Reset clears only control state; the value store is not cleared, and a node
// must be loaded or evaluated before it is used as a fanin.
// When m_ready is low, the output register holds the result and the item in
// the evaluate stage waits; s_ready drops once that stage is also occupied.
// Nodes at or beyond MAX_NODES, or words at or beyond SIM_WORDS, read as zero
// and are not written, though the result still reports them.
`default_nettype none

module bit_parallel_netlist_gate_evaluator_unit
    import bpnge_pkg::*;
#(
    parameter int MAX_NODES = 1024,
    parameter int SIM_WORDS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire bpnge_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output bpnge_out_t      m_data
);

    localparam longint unsigned DEPTH = longint'(MAX_NODES) * longint'(SIM_WORDS);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [NODE_W-1:0]     node,
        input logic [WORD_IDX_W-1:0] word
    );
        return ADDR_W'(ADDR_W'(node) * ADDR_W'(SIM_WORDS) + ADDR_W'(word));
    endfunction

    function automatic logic in_store(
        input logic [NODE_W-1:0]     node,
        input logic [WORD_IDX_W-1:0] word
    );
        return (int'(node) < MAX_NODES) && (int'(word) < SIM_WORDS);
    endfunction

    // evaluate stage
    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [GATE_W-1:0]     s1_gate_reg;
    logic [NODE_W-1:0]     s1_dest_reg;
    logic [PAT_W-1:0]      s1_load_reg;
    logic [ADDR_W-1:0]     s1_wr_addr_reg;
    logic                  s1_wr_ok_reg;

    logic                  out_valid_reg;
    bpnge_out_t            out_data_reg;

    logic                  accept;
    logic                  s1_advance;
    logic [FANINS-1:0][ADDR_W-1:0] rd_addr;
    logic [FANINS-1:0]             rd_ok;
    logic [FANINS-1:0][PAT_W-1:0]  fanin_word;
    logic [PAT_W-1:0]      a, b, c, d;
    logic [PAT_W-1:0]      gate_word;
    logic [PAT_W-1:0]      s1_word;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    always_comb begin
        rd_addr[0] = store_addr(s_data.fanin_a, s_data.word_index);
        rd_addr[1] = store_addr(s_data.fanin_b, s_data.word_index);
        rd_addr[2] = store_addr(s_data.fanin_c, s_data.word_index);
        rd_addr[3] = store_addr(s_data.fanin_d, s_data.word_index);
        rd_ok[0]   = in_store(s_data.fanin_a, s_data.word_index);
        rd_ok[1]   = in_store(s_data.fanin_b, s_data.word_index);
        rd_ok[2]   = in_store(s_data.fanin_c, s_data.word_index);
        rd_ok[3]   = in_store(s_data.fanin_d, s_data.word_index);
    end

    bpnge_value_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_ok   (rd_ok),
        .rd_data (fanin_word),
        .wr_en   (s1_advance && s1_wr_ok_reg),
        .wr_addr (s1_wr_addr_reg),
        .wr_data (s1_word)
    );

    assign a = fanin_word[0];
    assign b = fanin_word[1];
    assign c = fanin_word[2];
    assign d = fanin_word[3];

    always_comb begin
        unique case (s1_gate_reg)
            GATE_BUF:    gate_word = a;
            GATE_INV:    gate_word = ~a;
            GATE_XOR:    gate_word = a ^ b;
            GATE_XNOR:   gate_word = ~(a ^ b);
            GATE_AND2:   gate_word = a & b;
            GATE_OR2:    gate_word = a | b;
            GATE_NAND2:  gate_word = ~(a & b);
            GATE_NAND3:  gate_word = ~(a & b & c);
            GATE_NAND4:  gate_word = ~(a & b & c & d);
            GATE_NOR2:   gate_word = ~(a | b);
            GATE_NOR3:   gate_word = ~(a | b | c);
            GATE_NOR4:   gate_word = ~(a | b | c | d);
            GATE_AOI21:  gate_word = ~((a & b) | c);
            GATE_AOI22:  gate_word = ~((a & b) | (c & d));
            GATE_OAI21:  gate_word = ~((a | b) & c);
            GATE_OAI22:  gate_word = ~((a | b) & (c | d));
            GATE_CONST0: gate_word = '0;
            GATE_CONST1: gate_word = '1;
            default:     gate_word = '0;
        endcase
    end

    assign s1_word = (s1_op_reg == OP_LOAD) ? s1_load_reg : gate_word;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg      <= s_data.op;
            s1_gate_reg    <= s_data.gate_type;
            s1_dest_reg    <= s_data.dest_node;
            s1_load_reg    <= s_data.load_word;
            s1_wr_addr_reg <= store_addr(s_data.dest_node, s_data.word_index);
            s1_wr_ok_reg   <= in_store(s_data.dest_node, s_data.word_index);
        end
        if (s1_advance) begin
            out_data_reg.result_node <= s1_dest_reg;
            out_data_reg.result_word <= s1_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

[src/bpnge_value_store.sv]
// Value store: one memory copy per fanin port, shared write, last-write forwarding.
`default_nettype none

module bpnge_value_store
    import bpnge_pkg::*;
#(
    parameter int ADDR_W = 14,
    parameter longint unsigned DEPTH = 16384
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [FANINS-1:0][ADDR_W-1:0] rd_addr,
    input  wire logic [FANINS-1:0]           rd_ok,
    output logic      [FANINS-1:0][PAT_W-1:0] rd_data,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [PAT_W-1:0]            wr_data
);

    logic [FANINS-1:0][ADDR_W-1:0] rd_addr_reg;
    logic [FANINS-1:0]             rd_ok_reg;
    logic [FANINS-1:0][PAT_W-1:0]  mem_q_reg;

    logic                          last_valid_reg;
    logic [ADDR_W-1:0]             last_addr_reg;
    logic [PAT_W-1:0]              last_data_reg;

    genvar g;
    generate
        for (g = 0; g < FANINS; g++) begin : g_copy
            logic [PAT_W-1:0] mem [DEPTH];

            always_ff @(posedge aclk) begin
                if (wr_en) begin
                    mem[wr_addr] <= wr_data;
                end
            end

            // read-before-write; a same-edge write is picked up by forwarding
            always_ff @(posedge aclk) begin
                if (rd_en) begin
                    mem_q_reg[g] <= mem[rd_addr[g]];
                end
            end

            always_comb begin
                if (!rd_ok_reg[g]) begin
                    rd_data[g] = '0;
                end else if (last_valid_reg && last_addr_reg == rd_addr_reg[g]) begin
                    rd_data[g] = last_data_reg;
                end else begin
                    rd_data[g] = mem_q_reg[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_addr_reg <= rd_addr;
            rd_ok_reg   <= rd_ok;
        end
        if (wr_en) begin
            last_addr_reg <= wr_addr;
            last_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_valid_reg <= 1'b0;
        end else if (wr_en) begin
            last_valid_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the bit-parallel netlist gate evaluator.
module testbench
    import bpnge_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES        = 1 << NODE_W;
    localparam int WORDS        = 1 << WORD_IDX_W;
    localparam int MAX_GAP      = 14;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam int LAST_GATE    = (1 << GATE_W) - 1;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    bpnge_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    bpnge_out_t m_data;

    bit_parallel_netlist_gate_evaluator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicted contents of the value store, plus which entries hold a word.
    logic [PAT_W-1:0]  node_words   [NODES*WORDS];
    bit                node_written [NODES*WORDS];
    int                written_nodes[WORDS][$];
    bpnge_out_t        pending_words[$];
    bpnge_out_t        oldest_word;
    logic [NODE_W-1:0]     last_dest = '0;
    logic [WORD_IDX_W-1:0] last_word = '0;

    int errors       = 0;
    int rx_wait      = 0;
    int quiet_cycles = 0;
    bit tx_fast      = 1'b0;
    bit rx_fast      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int store_index(input logic [NODE_W-1:0] node,
                                       input logic [WORD_IDX_W-1:0] word);
        return int'({node, word});
    endfunction

    function automatic int draw_gap(input bit fast);
        return fast ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [PAT_W-1:0] gate_output(input logic [GATE_W-1:0] gt,
                                                     input logic [PAT_W-1:0] a, b, c, d);
        case (gt)
            GATE_BUF:    return a;
            GATE_INV:    return ~a;
            GATE_XOR:    return a ^ b;
            GATE_XNOR:   return ~(a ^ b);
            GATE_AND2:   return a & b;
            GATE_OR2:    return a | b;
            GATE_NAND2:  return ~(a & b);
            GATE_NAND3:  return ~(a & b & c);
            GATE_NAND4:  return ~(a & b & c & d);
            GATE_NOR2:   return ~(a | b);
            GATE_NOR3:   return ~(a | b | c);
            GATE_NOR4:   return ~(a | b | c | d);
            GATE_AOI21:  return ~((a & b) | c);
            GATE_AOI22:  return ~((a & b) | (c & d));
            GATE_OAI21:  return ~((a | b) & c);
            GATE_OAI22:  return ~((a | b) & (c | d));
            GATE_CONST0: return '0;
            GATE_CONST1: return '1;
            default:     return '0;  // undefined gate codes act as const0
        endcase
    endfunction

    // Applies one accepted transfer to the predicted store and queues its result.
    function automatic void update_netlist_model(input bpnge_in_t item);
        int               idx;
        logic [PAT_W-1:0] value;
        bpnge_out_t       res;
        idx = store_index(item.dest_node, item.word_index);
        if (item.op == OP_LOAD) begin
            value = item.load_word;
        end else begin
            value = gate_output(item.gate_type,
                                node_words[store_index(item.fanin_a, item.word_index)],
                                node_words[store_index(item.fanin_b, item.word_index)],
                                node_words[store_index(item.fanin_c, item.word_index)],
                                node_words[store_index(item.fanin_d, item.word_index)]);
        end
        node_words[idx] = value;
        if (!node_written[idx]) begin
            node_written[idx] = 1'b1;
            written_nodes[item.word_index].push_back(int'(item.dest_node));
        end
        last_dest = item.dest_node;
        last_word = item.word_index;
        res.result_node = item.dest_node;
        res.result_word = value;
        pending_words.push_back(res);
    endfunction

    function automatic logic [PAT_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Gate code and fanins of a load are junk; the block must ignore them.
    function automatic bpnge_in_t load_item(input logic [NODE_W-1:0] node,
                                            input logic [WORD_IDX_W-1:0] word,
                                            input logic [PAT_W-1:0] value);
        bpnge_in_t item;
        item.op         = OP_LOAD;
        item.gate_type  = GATE_W'($urandom_range(0, LAST_GATE));
        item.dest_node  = node;
        item.word_index = word;
        item.fanin_a    = NODE_W'($urandom_range(0, NODES-1));
        item.fanin_b    = NODE_W'($urandom_range(0, NODES-1));
        item.fanin_c    = NODE_W'($urandom_range(0, NODES-1));
        item.fanin_d    = NODE_W'($urandom_range(0, NODES-1));
        item.load_word  = value;
        return item;
    endfunction

    // Fanins come only from written entries; often the node just written,
    // so the write-to-read forwarding path gets exercised.
    function automatic logic [NODE_W-1:0] pick_fanin(input logic [WORD_IDX_W-1:0] word);
        if (word == last_word && node_written[store_index(last_dest, word)]
                && $urandom_range(0, 2) == 0) begin
            return last_dest;
        end
        return NODE_W'(written_nodes[word][$urandom_range(0, written_nodes[word].size() - 1)]);
    endfunction

    function automatic bpnge_in_t gate_item(input logic [GATE_W-1:0] gt,
                                            input logic [WORD_IDX_W-1:0] word);
        bpnge_in_t item;
        item.op         = OP_EVAL;
        item.gate_type  = gt;
        item.word_index = word;
        item.fanin_a    = pick_fanin(word);
        item.fanin_b    = pick_fanin(word);
        item.fanin_c    = pick_fanin(word);
        item.fanin_d    = pick_fanin(word);
        item.load_word  = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) begin
            item.dest_node = item.fanin_a;  // in-place update
        end else begin
            item.dest_node = NODE_W'($urandom_range(0, NODES-1));
        end
        return item;
    endfunction

    function automatic bpnge_in_t random_item();
        logic [WORD_IDX_W-1:0] word;
        logic [GATE_W-1:0]     gt;
        if ($urandom_range(0, 3) == 0) begin
            word = WORD_IDX_W'($urandom_range(0, WORDS-1));
        end else begin
            word = last_word;
        end
        if (written_nodes[word].size() == 0 || $urandom_range(0, 4) == 0) begin
            return load_item(NODE_W'($urandom_range(0, NODES-1)), word, random_word());
        end
        if ($urandom_range(0, 19) == 0) begin
            gt = GATE_W'($urandom_range(GATE_CONST1 + 1, LAST_GATE));
        end else begin
            gt = GATE_W'($urandom_range(0, GATE_CONST1));
        end
        return gate_item(gt, word);
    endfunction

    task automatic send_item(input bpnge_in_t item);
        int gap;
        gap = draw_gap(tx_fast);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        update_netlist_model(item);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic test_load_extremes();
        bpnge_in_t item;
        send_item(load_item(0, 0, '0));
        send_item(load_item(NODE_W'(NODES-1), WORD_IDX_W'(WORDS-1), '1));
        // four fanin words that together hold every input combination
        send_item(load_item(4, 0, 64'hFF00_FF00_FF00_FF00));
        send_item(load_item(5, 0, 64'hF0F0_F0F0_F0F0_F0F0));
        send_item(load_item(6, 0, 64'hCCCC_CCCC_CCCC_CCCC));
        send_item(load_item(7, 0, 64'hAAAA_AAAA_AAAA_AAAA));
        item = gate_item(GATE_BUF, WORD_IDX_W'(WORDS-1));
        item.dest_node = 0;
        send_item(item);
        item = gate_item(GATE_INV, WORD_IDX_W'(WORDS-1));
        item.dest_node = NODE_W'(NODES-1);
        send_item(item);
    endtask

    task automatic test_gate_types();
        bpnge_in_t item;
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        // every defined gate, then the first and last undefined codes
        for (int g = 0; g <= GATE_CONST1 + 2; g++) begin
            item = gate_item(GATE_W'((g > GATE_CONST1 + 1) ? LAST_GATE : g), 0);
            item.fanin_a   = 4;
            item.fanin_b   = 5;
            item.fanin_c   = 6;
            item.fanin_d   = 7;
            item.dest_node = NODE_W'(16 + g);
            send_item(item);
        end
        wait_drained();
    endtask

    task automatic test_random_netlist();
        for (int phase = 0; phase < PHASES; phase++) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
            if (phase % 4 == 3) wait_drained();
        end
    endtask

    // Result side: ready drops for a drawn number of cycles after each transfer.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: node %0d word %h",
                         $time, m_data.result_node, m_data.result_word);
            end else begin
                oldest_word = pending_words.pop_front();
                if (m_data.result_node !== oldest_word.result_node) begin
                    errors++;
                    $display("%0t: result_node expected %0d actual %0d", $time,
                             oldest_word.result_node, m_data.result_node);
                end
                if (m_data.result_word !== oldest_word.result_word) begin
                    errors++;
                    $display("%0t: result_word expected %h actual %h", $time,
                             oldest_word.result_word, m_data.result_word);
                end
            end
            rx_wait = draw_gap(rx_fast);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);
        test_load_extremes();
        test_gate_types();
        test_random_netlist();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
